>>> hw/rtl/ktmke_pkg.sv
// ----------------------------------------------------------------------------
// ktmke_pkg
// Shared widths, defaults and controller/datapath handshake types for the
// keyed table with smallest-key eviction.
// ----------------------------------------------------------------------------
package ktmke_pkg;

    localparam int KEY_W       = 64;
    localparam int INDEX_W     = 8;
    localparam int ENTRIES_DEF = 256;

    localparam logic [KEY_W-1:0] KEY_ALL_ONES = {KEY_W{1'b1}};

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    // status from the datapath back to the controller
    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } ctrl_status_t;

endpackage

>>> hw/rtl/ktmke_if.sv
// ----------------------------------------------------------------------------
// ktmke_if
// Valid/ready channels for the lookup key and the lookup result.
// ----------------------------------------------------------------------------
interface ktmke_in_if;
    import ktmke_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] lookup_key;

    modport source (output valid, output lookup_key, input ready);
    modport sink   (input valid, input lookup_key, output ready);
endinterface

interface ktmke_out_if;
    import ktmke_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] entry_index;
    logic               hit;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;

    modport source (output valid, output entry_index, output hit, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input entry_index, input hit, input evicted,
                    input evicted_key, output ready);
endinterface

>>> hw/rtl/keyed_table_min_key_eviction.sv
// ----------------------------------------------------------------------------
// keyed_table_min_key_eviction
// Associative key table: hit lookup, lowest free entry claim, otherwise
// eviction of the smallest stored key.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  lookup    in   valid/ready   lookup_key[63:0]
//  result    out  valid/ready   entry_index[7:0], hit, evicted, evicted_key[63:0]
//
//  an item is accepted, then scanned, then finished; the scan makes one key
//  memory read per cycle, over every occupied entry on a miss and over those
//  up to one past the match on a hit; the result goes valid as the input goes
//  ready
//  reset empties the table at once through the fill count, no clearing pass
//  a stalled result holds back only the finish of the next item
// ----------------------------------------------------------------------------
module keyed_table_min_key_eviction #(
    parameter int ENTRIES = ktmke_pkg::ENTRIES_DEF
) (
    input logic         clk,
    input logic         rst_n,
    ktmke_in_if.sink    lookup,
    ktmke_out_if.source result
);
    import ktmke_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic         in_ready;

    assign lookup.ready = in_ready;

    ktmke_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (lookup.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ktmke_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_key (lookup.lookup_key),
        .cmd        (cmd),
        .status     (status),
        .result     (result)
    );

endmodule

>>> hw/rtl/ktmke_ctrl.sv
// ----------------------------------------------------------------------------
// ktmke_ctrl
// Sequencer: accepts one item, runs the table scan, then hands the result
// to the output register.
// ----------------------------------------------------------------------------
module ktmke_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  ktmke_pkg::ctrl_status_t status,
    output ktmke_pkg::ctrl_cmd_t    cmd
);
    import ktmke_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && ready_reg)
                    begin
                        state_reg <= ST_SCAN;
                        ready_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    if (status.scan_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // wait for the output register to free up
                    if (!status.out_busy)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign in_ready   = ready_reg;
    assign cmd.start  = in_valid && ready_reg;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.finish = (state_reg == ST_FINISH) && !status.out_busy;

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> state_reg == ST_IDLE)
        else $error("ready raised outside idle");

    a_start_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> cmd.scan)
        else $error("accepted item did not enter the scan");

    a_finish_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> ready_reg && !cmd.scan)
        else $error("controller did not return to idle after finishing");
`endif

endmodule

>>> hw/rtl/ktmke_datapath.sv
// ----------------------------------------------------------------------------
// ktmke_datapath
// Key memory, fill count, scan pointer, match and minimum trackers, and the
// output register.
// ----------------------------------------------------------------------------
module ktmke_datapath #(
    parameter int ENTRIES = ktmke_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ktmke_pkg::KEY_W-1:0] lookup_key,
    input  ktmke_pkg::ctrl_cmd_t        cmd,
    output ktmke_pkg::ctrl_status_t     status,
    ktmke_out_if.source                 result
);
    import ktmke_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    logic [KEY_W-1:0] key_mem [ENTRIES];

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   rd_data_reg;
    logic [KEY_W-1:0]   min_key_reg;
    logic [CW-1:0]      fill_reg;
    logic [CW-1:0]      issue_reg;
    logic [IW-1:0]      cmp_idx_reg;
    logic [IW-1:0]      hit_idx_reg;
    logic [IW-1:0]      min_idx_reg;
    logic               cmp_vld_reg;
    logic               hit_reg;
    logic               have_min_reg;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_hit_reg;
    logic               out_evict_reg;
    logic [KEY_W-1:0]   out_ekey_reg;

    logic          issue_en;
    logic          is_full;
    logic [IW-1:0] target;
    logic          mem_we;
    logic          do_evict;
    logic          cmp_match;
    logic          cmp_less;

    // valid entries always form a prefix, so the fill count is the valid map
    assign issue_en  = cmd.scan && !hit_reg && (issue_reg != fill_reg);
    assign is_full   = (fill_reg == FULL);
    assign target    = is_full ? min_idx_reg : fill_reg[IW-1:0];
    assign mem_we    = cmd.finish && !hit_reg;
    assign do_evict  = !hit_reg && is_full;
    assign cmp_match = cmp_vld_reg && (rd_data_reg == key_reg);
    assign cmp_less  = !have_min_reg || (rd_data_reg < min_key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            issue_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            have_min_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                issue_reg    <= '0;
                cmp_vld_reg  <= 1'b0;
                hit_reg      <= 1'b0;
                have_min_reg <= 1'b0;
            end
            else
            begin
                cmp_vld_reg <= issue_en;
                if (issue_en)
                begin
                    issue_reg <= issue_reg + 1'b1;
                end
                if (cmp_match)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmp_vld_reg && cmp_less)
                begin
                    have_min_reg <= 1'b1;
                end
            end
            if (mem_we && !is_full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= lookup_key;
        end
        if (issue_en)
        begin
            rd_data_reg <= key_mem[issue_reg[IW-1:0]];
            cmp_idx_reg <= issue_reg[IW-1:0];
        end
        if (cmp_match)
        begin
            hit_idx_reg <= cmp_idx_reg;
        end
        if (cmp_vld_reg && cmp_less)
        begin
            min_key_reg <= rd_data_reg;
            min_idx_reg <= cmp_idx_reg;
        end
        if (cmd.finish)
        begin
            out_index_reg <= INDEX_W'(hit_reg ? hit_idx_reg : target);
            out_hit_reg   <= hit_reg;
            out_evict_reg <= do_evict;
            out_ekey_reg  <= do_evict ? min_key_reg : '0;
        end
        if (mem_we)
        begin
            key_mem[target] <= key_reg;
        end
    end

    // scan ends on a match or once every valid entry has been compared
    assign status.scan_done = hit_reg || ((issue_reg == fill_reg) && !cmp_vld_reg);
    assign status.out_busy  = out_valid_reg && !result.ready;

    assign result.valid       = out_valid_reg;
    assign result.entry_index = out_index_reg;
    assign result.hit         = out_hit_reg;
    assign result.evicted     = out_evict_reg;
    assign result.evicted_key = out_ekey_reg;

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL && issue_reg <= fill_reg)
        else $error("fill count or scan pointer out of range");

    a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_evict_reg |-> is_full)
        else $error("eviction reported with a free entry left");

    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_hit_reg |-> !out_evict_reg && out_ekey_reg == '0)
        else $error("hit result carries eviction data");

    a_finish_grows_fill: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && !is_full |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("claim of a free entry did not advance the fill count");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed table with smallest-key eviction. Keys
// mix reuse of recent keys, dense small values, values near all-ones and
// full-width random values, so that the table fills, hits and evicts. A
// shadow table predicts every result, under phases of sender idling and
// receiver stalling.
// ----------------------------------------------------------------------------
module tb;
    import ktmke_pkg::*;

    localparam int NUM_ENTRIES  = ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 3000;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HISTORY_LEN  = 400;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [INDEX_W-1:0] entry_index;
        logic               hit;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
    } lookup_result_t;

    // shadow of the key table and the results still owed by the block
    class table_scoreboard;
        bit             slot_used[NUM_ENTRIES];
        key_t           slot_key[NUM_ENTRIES];
        lookup_result_t owed[$];
        int             errors;

        function void note_lookup(key_t key);
            lookup_result_t r;
            int             free_slot;
            int             min_slot;
            int             victim;
            int             i;
            r         = '0;
            free_slot = -1;
            min_slot  = -1;
            for (i = 0; i < NUM_ENTRIES; i++)
            begin
                if (slot_used[i])
                begin
                    if (slot_key[i] == key)
                    begin
                        r.entry_index = INDEX_W'(i);
                        r.hit         = 1'b1;
                        owed.push_back(r);
                        return;
                    end
                    if (min_slot < 0 || slot_key[i] < slot_key[min_slot])
                        min_slot = i;
                end
                else if (free_slot < 0)
                    free_slot = i;
            end
            if (free_slot >= 0)
                victim = free_slot;
            else
            begin
                victim        = min_slot;
                r.evicted     = 1'b1;
                r.evicted_key = slot_key[victim];
            end
            slot_used[victim] = 1'b1;
            slot_key[victim]  = key;
            r.entry_index     = INDEX_W'(victim);
            owed.push_back(r);
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t want;
            if (owed.size() == 0)
            begin
                $error("result item with nothing outstanding: index %0d", got.entry_index);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.entry_index !== want.entry_index)
            begin
                $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
                errors++;
            end
            if (got.hit !== want.hit)
            begin
                $error("hit: expected %0b, got %0b", want.hit, got.hit);
                errors++;
            end
            if (got.evicted !== want.evicted)
            begin
                $error("evicted: expected %0b, got %0b", want.evicted, got.evicted);
                errors++;
            end
            if (got.evicted_key !== want.evicted_key)
            begin
                $error("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key);
                errors++;
            end
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ktmke_in_if  lookup ();
    ktmke_out_if result ();

    keyed_table_min_key_eviction dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .lookup (lookup),
        .result (result)
    );

    table_scoreboard book = new;

    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_request;
    int   quiet_cycles;
    key_t recent_keys[$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog: cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((lookup.valid && lookup.ready) || (result.valid && result.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            @(posedge clk);
            if (result.valid && result.ready)
                book.check_result('{result.entry_index, result.hit,
                                    result.evicted, result.evicted_key});
        end
    end

    task automatic send_key(input key_t key);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            lookup.valid <= 1'b0;
            @(posedge clk);
        end
        lookup.valid      <= 1'b1;
        lookup.lookup_key <= key;
        do
            @(posedge clk);
        while (!lookup.ready);
        book.note_lookup(key);
        recent_keys.push_back(key);
        if (recent_keys.size() > HISTORY_LEN)
            void'(recent_keys.pop_front());
    endtask

    task automatic wait_drained();
        lookup.valid <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic key_t pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35 && recent_keys.size() != 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else if (roll < 60)
            return key_t'($urandom_range(0, 511));
        else if (roll < 70)
            return KEY_ALL_ONES - key_t'($urandom_range(0, 255));
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        key_t directed_keys[$];
        int   phase;
        int   n;

        rst_n             = 1'b0;
        lookup.valid      = 1'b0;
        lookup.lookup_key = '0;
        result.ready      = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_request      = 1'b0;
        quiet_cycles      = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes first, then repeats of them so they come back as hits
        directed_keys = '{64'h0, KEY_ALL_ONES, 64'h0, KEY_ALL_ONES,
                          64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                          64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                          64'h1, KEY_ALL_ONES - 64'h1, 64'h5555_5555_5555_5555,
                          64'h1, 64'h8000_0000_0000_0000, 64'h0123_4567_89AB_CDEF,
                          64'hAAAA_AAAA_AAAA_AAAA, 64'h0};
        foreach (directed_keys[i])
            send_key(directed_keys[i]);
        wait_drained();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            for (n = 0; n < RANDOM_ITEMS / 4; n++)
            begin
                // long result hold-off while the sender keeps offering keys, table full by now
                if (phase == 2 && n == 100)
                    hold_request = 1'b1;
                send_key(pick_key());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
